@@ rtl/rqsw_pkg.sv @@
// Shared types and constants of the stop-and-wait retransmit queue.
package rqsw_pkg;

    // Event kinds carried by an input beat.
    typedef enum logic [1:0] {
        KIND_ADD     = 2'd0,
        KIND_TRY     = 2'd1,
        KIND_CONFIRM = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    // Result codes carried by an output beat.
    typedef enum logic [3:0] {
        ST_EMPTY        = 4'd0,
        ST_SENT         = 4'd1,
        ST_EXHAUSTED    = 4'd2,
        ST_POPPED       = 4'd3,
        ST_WAITING      = 4'd4,
        ST_ADDED        = 4'd5,
        ST_REJECTED     = 4'd6,
        ST_CONFIRM_OK   = 4'd7,
        ST_CONFIRM_IGN  = 4'd8,
        ST_TICKED       = 4'd9
    } t_status;

    // Configuration register indexes.
    localparam logic CFG_RESEND_GAP = 1'b0;
    localparam logic CFG_MAX_TRIES  = 1'b1;

    localparam logic [15:0] RESEND_GAP_RST = 16'd3;
    localparam logic [7:0]  MAX_TRIES_RST  = 8'd3;
    localparam logic [15:0] TICKS_MAX      = 16'hFFFF;

    // One classified command waiting between the front and back parts.
    typedef struct packed {
        t_kind       kind;
        logic [31:0] payload;
    } t_cmd;

    // Executor states.
    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_READ = 1'b1
    } t_back_state;

endpackage

@@ rtl/rqsw_if.sv @@
// Channel interfaces of the retransmit queue: input, result and configuration.
interface rqsw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] payload_in;

    modport source (output valid, output kind, output payload_in, input ready);
    modport sink   (input valid, input kind, input payload_in, output ready);
endinterface

interface rqsw_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] payload_out;
    logic        queue_full;
    logic [4:0]  queue_count;

    modport source (output valid, output status, output payload_out,
                    output queue_full, output queue_count, input ready);
    modport sink   (input valid, input status, input payload_out,
                    input queue_full, input queue_count, output ready);
endinterface

interface rqsw_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/rqsw_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module rqsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/rqsw_front.sv @@
// Front part: accepts input beats, classifies them and buffers them in a two-entry queue.
module rqsw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rqsw_in_if.sink        i_in,
    output logic           o_cmd_valid,
    output rqsw_pkg::t_cmd o_cmd,
    input  logic           i_cmd_ready
);

    rqsw_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_cnt;

    logic           w_push;
    logic           w_pop;
    rqsw_pkg::t_cmd w_cmd;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        w_cmd.kind    = rqsw_pkg::t_kind'(i_in.kind);
        w_cmd.payload = i_in.payload_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

@@ rtl/rqsw_back.sv @@
// Back part: executes queued commands against the ring, the retry state and the output register.
module rqsw_back #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  rqsw_pkg::t_cmd i_cmd,
    output logic           o_cmd_ready,
    rqsw_cfg_if.sink       i_cfg,
    rqsw_out_if.source     o_out
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    rqsw_pkg::t_back_state r_state, n_state;
    logic [15:0]       r_gap;
    logic [7:0]        r_max;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [7:0]        r_tries, n_tries;
    logic              r_sent, n_sent;
    logic              r_conf, n_conf;
    logic [15:0]       r_ticks, n_ticks;

    logic              r_out_valid, n_out_valid;
    rqsw_pkg::t_status r_status, n_status;
    logic [31:0]       r_payload, n_payload;
    logic              r_full, n_full;
    logic [4:0]        r_count, n_count;

    logic                    w_wr_en;
    logic [PAYLOAD_BITS-1:0] w_wr_data;
    logic [PAYLOAD_BITS-1:0] w_rd_data;
    logic [7:0]              w_tries_dec;

    assign i_cfg.ready = 1'b1;
    assign o_cmd_ready = (r_state == rqsw_pkg::BK_EXEC) && (!r_out_valid || o_out.ready);
    assign w_wr_data   = PAYLOAD_BITS'(i_cmd.payload);
    assign w_tries_dec = (r_tries != 8'd0) ? r_tries - 8'd1 : 8'd0;

    // The read port always looks at the head entry; a send picks the word up in the cycle after, in the read state.
    rqsw_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_wr_data),
        .i_rd_addr (r_head),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        rqsw_pkg::t_status w_status;
        logic              w_load;

        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_tries     = r_tries;
        n_sent      = r_sent;
        n_conf      = r_conf;
        n_ticks     = r_ticks;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_payload   = r_payload;
        n_full      = r_full;
        n_count     = r_count;
        w_wr_en     = 1'b0;
        w_status    = rqsw_pkg::ST_EMPTY;
        w_load      = 1'b0;

        unique case (r_state)
            rqsw_pkg::BK_EXEC: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    w_load = 1'b1;
                    unique case (i_cmd.kind)
                        rqsw_pkg::KIND_ADD: begin
                            if (r_held == FULL_CNT) begin
                                w_status = rqsw_pkg::ST_REJECTED;
                            end else begin
                                w_wr_en  = 1'b1;
                                n_tail   = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                                n_held   = r_held + 1'b1;
                                w_status = rqsw_pkg::ST_ADDED;
                            end
                        end
                        rqsw_pkg::KIND_TRY: begin
                            priority if (r_held == '0) begin
                                w_status = rqsw_pkg::ST_EMPTY;
                            end else if (!r_sent) begin
                                n_sent  = 1'b1;
                                n_conf  = 1'b0;
                                n_ticks = '0;
                                n_tries = w_tries_dec;
                                w_load  = 1'b0;
                                n_state = rqsw_pkg::BK_READ;
                            end else if (!r_conf) begin
                                priority if (r_tries != 8'd0 && r_ticks > r_gap) begin
                                    n_ticks = '0;
                                    n_tries = w_tries_dec;
                                    w_load  = 1'b0;
                                    n_state = rqsw_pkg::BK_READ;
                                end else if (r_tries == 8'd0) begin
                                    w_status = rqsw_pkg::ST_EXHAUSTED;
                                end else begin
                                    w_status = rqsw_pkg::ST_WAITING;
                                end
                            end else begin
                                n_head   = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                                n_held   = r_held - 1'b1;
                                n_sent   = 1'b0;
                                n_conf   = 1'b0;
                                n_tries  = r_max;
                                w_status = rqsw_pkg::ST_POPPED;
                            end
                        end
                        rqsw_pkg::KIND_CONFIRM: begin
                            if (r_sent) begin
                                n_conf   = 1'b1;
                                w_status = rqsw_pkg::ST_CONFIRM_OK;
                            end else begin
                                w_status = rqsw_pkg::ST_CONFIRM_IGN;
                            end
                        end
                        rqsw_pkg::KIND_TICK: begin
                            if (r_ticks != rqsw_pkg::TICKS_MAX) begin
                                n_ticks = r_ticks + 16'd1;
                            end
                            w_status = rqsw_pkg::ST_TICKED;
                        end
                        default: begin
                            w_status = rqsw_pkg::ST_TICKED;
                        end
                    endcase
                end
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_status    = w_status;
                    n_payload   = '0;
                    n_full      = (n_held == FULL_CNT);
                    n_count     = 5'(n_held);
                end
            end
            rqsw_pkg::BK_READ: begin
                // The output register is empty here: nothing was loaded when the send began.
                n_out_valid = 1'b1;
                n_status    = rqsw_pkg::ST_SENT;
                n_payload   = 32'(w_rd_data);
                n_full      = (r_held == FULL_CNT);
                n_count     = 5'(r_held);
                n_state     = rqsw_pkg::BK_EXEC;
            end
            default: begin
                n_state = rqsw_pkg::BK_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rqsw_pkg::BK_EXEC;
            r_gap       <= rqsw_pkg::RESEND_GAP_RST;
            r_max       <= rqsw_pkg::MAX_TRIES_RST;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_tries     <= rqsw_pkg::MAX_TRIES_RST;
            r_sent      <= 1'b0;
            r_conf      <= 1'b0;
            r_ticks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_tries     <= n_tries;
            r_sent      <= n_sent;
            r_conf      <= n_conf;
            r_ticks     <= n_ticks;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rqsw_pkg::CFG_RESEND_GAP: r_gap <= i_cfg.data;
                    rqsw_pkg::CFG_MAX_TRIES:  r_max <= i_cfg.data[7:0];
                    default: r_gap <= r_gap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_payload <= n_payload;
        r_full    <= n_full;
        r_count   <= n_count;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.payload_out = r_payload;
    assign o_out.queue_full  = r_full;
    assign o_out.queue_count = r_count;

endmodule

@@ rtl/retransmit_queue_stop_and_wait.sv @@
// Top level of the stop-and-wait retransmit queue.
// Each input beat is one event (add a payload, try to send, confirm, or one timer tick) and
// yields exactly one result beat. Beats pass through a two-entry command queue to an executor;
// a try that sends passes through a read state, since the head payload comes out of the
// payload RAM through its registered read port. A result waits in an output register, and the
// next event waits until it is taken. Configuration writes are taken in any cycle.
module retransmit_queue_stop_and_wait #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rqsw_in_if.sink    i_in,
    rqsw_cfg_if.sink   i_cfg,
    rqsw_out_if.source o_out
);

    logic           w_cmd_valid;
    logic           w_cmd_ready;
    rqsw_pkg::t_cmd w_cmd;

    rqsw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    rqsw_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule
